// File: src/stxd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the STX ASCII length deframer.
// No dependencies; compiled before the interfaces and modules.
package stxd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 14;
	localparam int unsigned POS_W = 14;

	// Header byte that holds the first length digit (start byte is byte 0)
	localparam int unsigned LENGTH_OFFSET = 5;

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

	localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h01;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] out_byte;
		logic              frame_first;
		logic              frame_last;
		logic              abort_previous;
		logic [LEN_W-1:0]  body_length;
	} result_t;

endpackage
`default_nettype wire

// File: src/stxd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Handshake channels of the deframer: byte input, result output, config write.
// Depends on stxd_pkg.
interface stxd_rx_if;
	logic                        valid;
	logic                        ready;
	logic [stxd_pkg::BYTE_W-1:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface stxd_tx_if;
	logic                        valid;
	logic                        ready;
	logic [stxd_pkg::BYTE_W-1:0] out_byte;
	logic                        frame_first;
	logic                        frame_last;
	logic                        abort_previous;
	logic [stxd_pkg::LEN_W-1:0]  body_length;
	modport source (output valid, output out_byte, output frame_first, output frame_last,
		output abort_previous, output body_length, input ready);
	modport sink (input valid, input out_byte, input frame_first, input frame_last,
		input abort_previous, input body_length, output ready);
endinterface

interface stxd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [stxd_pkg::BYTE_W-1:0] start_byte;
	modport source (output valid, output start_byte, input ready);
	modport sink (input valid, input start_byte, output ready);
endinterface
`default_nettype wire

// File: src/stxd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Frame parser: phase, byte position and length decode for one byte per step.
// Depends on stxd_pkg.
module stxd_parser #(
	parameter int unsigned HEADER_BYTES  = 10,
	parameter int unsigned LENGTH_DIGITS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [stxd_pkg::BYTE_W-1:0] byte_in_s1,
	input  wire logic [stxd_pkg::BYTE_W-1:0] start_byte,
	output stxd_pkg::result_t                result
);
	import stxd_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_BODY,
		PH_TRAILER
	} phase_t;

	localparam logic [POS_W:0] HDR_END = (POS_W+1)'(HEADER_BYTES);
	localparam logic [POS_W-1:0] DIG_LO = POS_W'(LENGTH_OFFSET);
	localparam logic [POS_W-1:0] DIG_HI = POS_W'(LENGTH_OFFSET + LENGTH_DIGITS);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             stopped_q, stopped_d;
	logic [POS_W:0]   pos_inc;
	logic [POS_W:0]   body_end;
	logic             is_digit;
	logic [LEN_W-1:0] digit;

	assign pos_inc  = {1'b0, pos_q} + 1'b1;
	assign body_end = HDR_END + {1'b0, len_q};
	assign is_digit = (byte_in_s1 >= ASCII_ZERO) && (byte_in_s1 <= ASCII_NINE);
	assign digit    = LEN_W'(byte_in_s1 - ASCII_ZERO);

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		len_d     = len_q;
		stopped_d = stopped_q;
		result    = '0;
		result.out_byte = byte_in_s1;
		if (byte_in_s1 == start_byte) begin
			// start byte opens a frame from any phase; inside a frame it voids the old one
			if (phase_q != PH_HUNT || byte_in_s1 == start_byte) begin
				result.valid          = 1'b1;
				result.frame_first    = 1'b1;
				result.abort_previous = (phase_q != PH_HUNT);
				phase_d   = PH_HEADER;
				pos_d     = POS_W'(1);
				len_d     = '0;
				stopped_d = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
				end
				PH_TRAILER: begin
					result.valid       = 1'b1;
					result.frame_last  = 1'b1;
					result.body_length = len_q;
					phase_d = PH_HUNT;
					pos_d   = '0;
				end
				PH_HEADER: begin
					result.valid = 1'b1;
					if (pos_q >= DIG_LO && pos_q < DIG_HI && !stopped_q) begin
						if (is_digit) begin
							len_d = (len_q << 3) + (len_q << 1) + digit;
						end else begin
							stopped_d = 1'b1;
						end
					end
					if (pos_inc >= HDR_END) begin
						phase_d = (len_d == '0) ? PH_TRAILER : PH_BODY;
					end
					pos_d = pos_inc[POS_W-1:0];
				end
				PH_BODY: begin
					result.valid = 1'b1;
					if (pos_inc >= body_end) begin
						phase_d = PH_TRAILER;
					end
					pos_d = pos_inc[POS_W-1:0];
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			pos_q     <= '0;
			len_q     <= '0;
			stopped_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			len_q     <= len_d;
			stopped_q <= stopped_d;
		end
	end

endmodule
`default_nettype wire

// File: src/stx_ascii_length_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// STX ASCII length deframer, top level.
// Channels: rx takes one stream byte per item; tx gives one frame byte per
// item with frame_first, frame_last, abort_previous and body_length
// (body_length is nonzero only on frame_last); cfg writes start_byte.
// Bytes outside a frame are dropped and produce no tx item.
// A byte accepted on rx passes the input register, then the result
// register, before it is presented on tx. Throughput: one byte per cycle
// while tx does not stall, set by the combinational parser step between
// the two registers.
// When tx stalls, the result register holds; the input register still
// takes one more byte, after which rx.ready drops until tx drains.
// Dropped bytes pass through even while tx stalls.
// Reset: parser back to hunting, both registers empty, start_byte = 0x01.
// cfg.ready is always high; a write takes effect on the next byte.
// Depends on stxd_pkg, stxd_ifs, stxd_parser.
module stx_ascii_length_deframer #(
	parameter int unsigned HEADER_BYTES  = 10,
	parameter int unsigned LENGTH_DIGITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	stxd_rx_if.sink    rx,
	stxd_tx_if.source  tx,
	stxd_cfg_if.sink   cfg
);
	import stxd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] start_q;
	logic              advance;
	result_t           result;
	result_t           out_q;

	// A dropped byte never needs the result register
	assign advance  = valid_s1 && (!result.valid || !out_q.valid || tx.ready);
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	stxd_parser #(
		.HEADER_BYTES (HEADER_BYTES),
		.LENGTH_DIGITS(LENGTH_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in_s1(byte_s1),
		.start_byte(start_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			start_q  <= START_BYTE_RESET;
			out_q    <= '0;
		end else begin
			if (cfg.valid) begin
				start_q <= cfg.start_byte;
			end
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && result.valid) begin
				out_q <= result;
			end else if (tx.ready) begin
				out_q.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.in_byte;
		end
	end

	assign tx.valid          = out_q.valid;
	assign tx.out_byte       = out_q.out_byte;
	assign tx.frame_first    = out_q.frame_first;
	assign tx.frame_last     = out_q.frame_last;
	assign tx.abort_previous = out_q.abort_previous;
	assign tx.body_length    = out_q.body_length;

endmodule
`default_nettype wire
